/* rtl/pcse_pkg.sv */
// Package for the PCI configuration scan engine.
// Types, register indexes, result kinds and address constants; no dependencies.
package pcse_pkg;

  localparam int BUS_COUNT_DEF = 256;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_MATCH_BY_ID  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WANT_CLASS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WANT_SUBCLASS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WANT_PROG_IF = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WANT_VENDOR  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_WANT_DEVICE  = 3'd5;

  localparam logic ACTION_START = 1'b0;
  localparam logic ACTION_DATA  = 1'b1;

  localparam logic [1:0] KIND_READ      = 2'd0;
  localparam logic [1:0] KIND_FOUND     = 2'd1;
  localparam logic [1:0] KIND_NOT_FOUND = 2'd2;

  localparam logic [31:0] CFG_ENABLE   = 32'h8000_0000;
  localparam logic [7:0]  OFF_ID       = 8'h00;
  localparam logic [7:0]  OFF_CLASS    = 8'h08;
  localparam logic [7:0]  OFF_HEADER   = 8'h0E;
  localparam logic [7:0]  OFF_MASK     = 8'hFC;
  localparam logic [15:0] VENDOR_EMPTY = 16'hFFFF;
  localparam logic [7:0]  PROG_IF_ANY  = 8'hFF;
  localparam int          HDR_MF_BIT   = 23;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_ID,
    PH_CLASS,
    PH_HEADER
  } phase_t;

  typedef struct packed {
    logic        match_by_id;
    logic [7:0]  want_class;
    logic [7:0]  want_subclass;
    logic [7:0]  want_prog_if;
    logic [15:0] want_vendor;
    logic [15:0] want_device;
  } cfg_t;

  typedef struct packed {
    logic        vld;
    logic [1:0]  kind;
    logic [31:0] config_address;
    logic [7:0]  found_bus;
    logic [4:0]  found_slot;
    logic [2:0]  found_func;
    logic        last;
  } res_t;

endpackage

/* rtl/pcse_cfg_regs.sv */
// Match configuration registers of the PCI configuration scan engine.
// Depends on pcse_pkg.
module pcse_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [pcse_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pcse_pkg::CFG_DATA_W-1:0] cfg_data,
  output pcse_pkg::cfg_t                  cfg
);
  import pcse_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_MATCH_BY_ID:   cfg_nxt.match_by_id   = cfg_data[0];
        CFG_WANT_CLASS:    cfg_nxt.want_class    = cfg_data[7:0];
        CFG_WANT_SUBCLASS: cfg_nxt.want_subclass = cfg_data[7:0];
        CFG_WANT_PROG_IF:  cfg_nxt.want_prog_if  = cfg_data[7:0];
        CFG_WANT_VENDOR:   cfg_nxt.want_vendor   = cfg_data;
        CFG_WANT_DEVICE:   cfg_nxt.want_device   = cfg_data;
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.match_by_id   <= 1'b0;
      cfg_r.want_class    <= 8'h00;
      cfg_r.want_subclass <= 8'h00;
      cfg_r.want_prog_if  <= PROG_IF_ANY;
      cfg_r.want_vendor   <= 16'h0000;
      cfg_r.want_device   <= 16'h0000;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* rtl/pcse_walk.sv */
// Scan sequencer: phase and bus/slot/function position, next-step decision per word.
// Depends on pcse_pkg.
module pcse_walk #(
  parameter int BUS_COUNT = pcse_pkg::BUS_COUNT_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           fire,
  input  logic           action,
  input  logic [31:0]    read_data,
  input  pcse_pkg::cfg_t cfg,
  output pcse_pkg::res_t res
);
  import pcse_pkg::*;

  localparam logic [8:0] BusLimit = 9'(BUS_COUNT);

  phase_t     phase_r, phase_nxt;
  logic [7:0] bus_r, bus_nxt;
  logic [4:0] slot_r, slot_nxt;
  logic [2:0] func_r, func_nxt;

  logic       whole_slot;
  logic       adv_end;
  logic [7:0] adv_bus;
  logic [4:0] adv_slot;
  logic [2:0] adv_func;
  logic       id_empty;
  logic       id_match;
  logic       class_match;
  logic [7:0] req_off;

  assign whole_slot = (phase_r == PH_HEADER) && !read_data[HDR_MF_BIT];
  assign id_empty   = read_data[15:0] == VENDOR_EMPTY;
  assign id_match   = (read_data[15:0] == cfg.want_vendor) &&
                      (read_data[31:16] == cfg.want_device);
  assign class_match = (read_data[31:24] == cfg.want_class) &&
                       (read_data[23:16] == cfg.want_subclass) &&
                       ((cfg.want_prog_if == PROG_IF_ANY) ||
                        (read_data[15:8] == cfg.want_prog_if));

  // next position when stepping on
  always_comb begin
    adv_end  = 1'b0;
    adv_bus  = bus_r;
    adv_slot = slot_r;
    adv_func = 3'd0;
    if (!whole_slot && (func_r != 3'd7)) begin
      adv_func = func_r + 3'd1;
    end else if (slot_r != 5'd31) begin
      adv_slot = slot_r + 5'd1;
    end else begin
      adv_slot = 5'd0;
      if (({1'b0, bus_r} + 9'd1) >= BusLimit) begin
        adv_end = 1'b1;
        adv_bus = 8'd0;
      end else begin
        adv_bus = bus_r + 8'd1;
      end
    end
  end

  always_comb begin
    logic do_adv;
    logic do_found;
    logic do_req;
    do_adv    = 1'b0;
    do_found  = 1'b0;
    do_req    = 1'b0;
    req_off   = OFF_ID;
    phase_nxt = phase_r;
    bus_nxt   = bus_r;
    slot_nxt  = slot_r;
    func_nxt  = func_r;

    if (fire) begin
      if (action == ACTION_START) begin
        bus_nxt   = 8'd0;
        slot_nxt  = 5'd0;
        func_nxt  = 3'd0;
        phase_nxt = PH_ID;
        do_req    = 1'b1;
      end else begin
        case (phase_r)
          PH_ID: begin
            if (id_empty) begin
              do_adv = 1'b1;
            end else if (cfg.match_by_id) begin
              if (id_match) begin
                do_found = 1'b1;
              end else if (func_r == 3'd0) begin
                phase_nxt = PH_HEADER;
                req_off   = OFF_HEADER;
                do_req    = 1'b1;
              end else begin
                do_adv = 1'b1;
              end
            end else begin
              phase_nxt = PH_CLASS;
              req_off   = OFF_CLASS;
              do_req    = 1'b1;
            end
          end
          PH_CLASS: begin
            if (class_match) begin
              do_found = 1'b1;
            end else if (func_r == 3'd0) begin
              phase_nxt = PH_HEADER;
              req_off   = OFF_HEADER;
              do_req    = 1'b1;
            end else begin
              do_adv = 1'b1;
            end
          end
          PH_HEADER: do_adv = 1'b1;
          default:   phase_nxt = phase_r;
        endcase
      end
    end

    if (do_adv) begin
      bus_nxt  = adv_bus;
      slot_nxt = adv_slot;
      func_nxt = adv_func;
      if (adv_end) begin
        phase_nxt = PH_IDLE;
      end else begin
        phase_nxt = PH_ID;
        do_req    = 1'b1;
      end
    end
    if (do_found) begin
      phase_nxt = PH_IDLE;
    end

    res.vld            = do_adv || do_found || do_req;
    res.kind           = KIND_READ;
    res.config_address = CFG_ENABLE |
                         {8'h00, bus_nxt, slot_nxt, func_nxt, req_off & OFF_MASK};
    res.found_bus      = bus_nxt;
    res.found_slot     = slot_nxt;
    res.found_func     = func_nxt;
    res.last           = 1'b0;
    if (do_found) begin
      res.kind           = KIND_FOUND;
      res.config_address = 32'd0;
      res.last           = 1'b1;
    end else if (do_adv && adv_end) begin
      res.kind           = KIND_NOT_FOUND;
      res.config_address = 32'd0;
      res.found_bus      = 8'd0;
      res.found_slot     = 5'd0;
      res.found_func     = 3'd0;
      res.last           = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      bus_r   <= 8'd0;
      slot_r  <= 5'd0;
      func_r  <= 3'd0;
    end else begin
      phase_r <= phase_nxt;
      bus_r   <= bus_nxt;
      slot_r  <= slot_nxt;
      func_r  <= func_nxt;
    end
  end

endmodule

/* rtl/pci_config_scan_engine_unit.sv */
// PCI configuration scan engine, top level: input word register, sequencer, result register.
// A word goes from the input register to the result register; out_stall can hold it there.
// Throughput: one word per cycle unless out_stall holds the result; next step is combinational.
// A word that yields no result (data while idle) just leaves the input register.
// Reset (rst_n low, synchronous) empties both registers, sets the scan idle at position
// zero and loads register defaults (programming interface 255 = any).
module pci_config_scan_engine_unit #(
  parameter int BUS_COUNT = pcse_pkg::BUS_COUNT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_action,
  input  logic [31:0]                     in_read_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [1:0]                      out_kind,
  output logic [31:0]                     out_config_address,
  output logic [7:0]                      out_found_bus,
  output logic [4:0]                      out_found_slot,
  output logic [2:0]                      out_found_func,
  output logic                            out_last,
  input  logic                            cfg_we,
  input  logic [pcse_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pcse_pkg::CFG_DATA_W-1:0] cfg_data
);
  import pcse_pkg::*;

  cfg_t        cfg;
  res_t        res;
  res_t        out_r;
  logic        in_vld_r, in_vld_nxt;
  logic        action_r;
  logic [31:0] data_r;
  logic        pipe_move;
  logic        in_take;
  logic        fire;

  assign pipe_move = !out_r.vld || !out_stall;
  assign in_stall  = in_vld_r && !pipe_move;
  assign in_take   = in_valid && !in_stall;
  assign fire      = in_vld_r && pipe_move;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_take) begin
      in_vld_nxt = 1'b1;
    end else if (pipe_move) begin
      in_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_r.vld <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
      if (pipe_move) begin
        out_r.vld <= res.vld;
      end
    end
    if (in_take) begin
      action_r <= in_action;
      data_r   <= in_read_data;
    end
    if (pipe_move && res.vld) begin
      out_r.kind           <= res.kind;
      out_r.config_address <= res.config_address;
      out_r.found_bus      <= res.found_bus;
      out_r.found_slot     <= res.found_slot;
      out_r.found_func     <= res.found_func;
      out_r.last           <= res.last;
    end
  end

  pcse_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pcse_walk #(
    .BUS_COUNT (BUS_COUNT)
  ) u_walk (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .action    (action_r),
    .read_data (data_r),
    .cfg       (cfg),
    .res       (res)
  );

  assign out_valid          = out_r.vld;
  assign out_kind           = out_r.kind;
  assign out_config_address = out_r.config_address;
  assign out_found_bus      = out_r.found_bus;
  assign out_found_slot     = out_r.found_slot;
  assign out_found_func     = out_r.found_func;
  assign out_last           = out_r.last;

endmodule
